/* src/sensor_frame_receiver_unit_defines.svh */
// assertion macros for the frame receiver
`ifndef SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define SFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication, clocked on clk_i, off while in reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

/* src/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

  // frame layout
  localparam int unsigned PAYLOAD_BYTES_DEF = 17;
  localparam logic [7:0]  HDR1              = 8'hAA;
  localparam logic [7:0]  HDR2              = 8'h55;
  localparam logic [7:0]  HDR_SUM           = 8'hFF;

  // register reset values
  localparam logic [7:0]  HUNT_LIMIT_RST    = 8'd200;
  localparam logic [15:0] TIMEOUT_RST       = 16'd1000;

  // apb port geometry
  localparam int unsigned APB_ADDR_W        = 3;
  localparam int unsigned APB_DATA_W        = 32;
  localparam int unsigned REG_SEL_BIT       = 2;

  typedef enum logic {
    REG_HUNT_LIMIT = 1'b0,
    REG_TIMEOUT    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADLEN  = 3'd1,
    ST_BADSUM  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_NOHDR   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_SUM   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  hunt_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // what one accepted request leaves for the output side
  typedef struct packed {
    logic    err;
    status_e status;
    logic    start;
  } res_t;

endpackage

`default_nettype wire

/* src/sfr_if.sv */
`default_nettype none

// input channel: one received byte or one time tick per request
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// output channel: one payload byte or one error per request
interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic       last;

  modport source (output valid, output status, output data_byte, output byte_index,
                  output last, input ready);
  modport sink   (input valid, input status, input data_byte, input byte_index,
                  input last, output ready);
endinterface

`default_nettype wire

/* src/sfr_regs.sv */
`default_nettype none

module sfr_regs
  import sfr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[REG_SEL_BIT]);
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HUNT_LIMIT: cfg_d.hunt_limit    = pwdata[7:0];
        REG_TIMEOUT:    cfg_d.timeout_ticks = pwdata[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hunt_limit    <= HUNT_LIMIT_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_HUNT_LIMIT: prdata = {24'd0, cfg_q.hunt_limit};
      REG_TIMEOUT:    prdata = {16'd0, cfg_q.timeout_ticks};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/sfr_parser.sv */
`default_nettype none

module sfr_parser
  import sfr_pkg::*;
#(
  parameter  int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             acc_i,
  input  wire logic             cmd_i,
  input  wire logic [7:0]       rx_byte_i,
  output res_t                  res_o,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [7:0]            wdata_o
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       hunt_q, hunt_d;
  logic [15:0]      idle_q, idle_d;
  logic             idle_rep_q, idle_rep_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       hunt_inc;

  assign hunt_inc = hunt_q + 8'd1;
  assign waddr_o  = cnt_q[IDX_W-1:0];
  assign wdata_o  = rx_byte_i;

  // frame state machine, one request per cycle while acc_i is high
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    hunt_d     = hunt_q;
    idle_d     = idle_q;
    idle_rep_d = idle_rep_q;
    sum_d      = sum_q;
    len_d      = len_q;
    res_o      = '{err: 1'b0, status: ST_OK, start: 1'b0};
    we_o       = 1'b0;
    if (acc_i) begin
      if (cmd_i) begin
        // time tick: idle counter saturates, timeout once per idle spell
        if (idle_q != 16'hFFFF) begin
          idle_d = idle_q + 16'd1;
        end
        if (idle_d >= cfg_i.timeout_ticks && !idle_rep_q) begin
          idle_rep_d = 1'b1;
          phase_d    = PH_HUNT1;
          hunt_d     = '0;
          cnt_d      = '0;
          sum_d      = '0;
          res_o.err    = 1'b1;
          res_o.status = ST_TIMEOUT;
        end
      end else begin
        idle_d     = '0;
        idle_rep_d = 1'b0;
        case (phase_q)
          PH_HUNT1, PH_HUNT2: begin
            if (phase_q == PH_HUNT2 && rx_byte_i == HDR2) begin
              phase_d = PH_LEN;
              hunt_d  = '0;
              sum_d   = HDR_SUM;
              cnt_d   = '0;
            end else if (hunt_inc >= cfg_i.hunt_limit) begin
              phase_d = PH_HUNT1;
              hunt_d  = '0;
              cnt_d   = '0;
              sum_d   = '0;
              res_o.err    = 1'b1;
              res_o.status = ST_NOHDR;
            end else begin
              hunt_d  = hunt_inc;
              phase_d = (rx_byte_i == HDR1) ? PH_HUNT2 : PH_HUNT1;
            end
          end
          PH_LEN: begin
            len_d   = rx_byte_i;
            sum_d   = sum_q + rx_byte_i;
            cnt_d   = '0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            we_o  = 1'b1;
            sum_d = sum_q + rx_byte_i;
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(PAYLOAD_BYTES - 1)) begin
              phase_d = PH_SUM;
            end
          end
          PH_SUM: begin
            phase_d = PH_HUNT1;
            hunt_d  = '0;
            cnt_d   = '0;
            sum_d   = '0;
            // length is checked before the checksum
            if (len_q != 8'(PAYLOAD_BYTES)) begin
              res_o.err    = 1'b1;
              res_o.status = ST_BADLEN;
            end else if (sum_q != rx_byte_i) begin
              res_o.err    = 1'b1;
              res_o.status = ST_BADSUM;
            end else begin
              res_o.start  = 1'b1;
            end
          end
          default: begin
            phase_d = PH_HUNT1;
            hunt_d  = '0;
            cnt_d   = '0;
            sum_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT1;
      cnt_q      <= '0;
      hunt_q     <= '0;
      idle_q     <= '0;
      idle_rep_q <= 1'b0;
      sum_q      <= '0;
      len_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      hunt_q     <= hunt_d;
      idle_q     <= idle_d;
      idle_rep_q <= idle_rep_d;
      sum_q      <= sum_d;
      len_q      <= len_d;
    end
  end

endmodule

`default_nettype wire

/* src/sfr_store.sv */
`default_nettype none

module sfr_store
  import sfr_pkg::*;
#(
  parameter  int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem [PAYLOAD_BYTES];
  logic [7:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/sfr_emit.sv */
`default_nettype none

module sfr_emit
  import sfr_pkg::*;
#(
  parameter  int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire res_t             res_i,
  input  wire logic [7:0]       rdata_i,
  output logic      [IDX_W-1:0] raddr_o,
  output logic                  busy_o,
  sfr_out_if.source             out_o
);

  logic             burst_q, burst_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  status_e          status_q, status_d;
  logic [7:0]       data_q, data_d;
  logic [4:0]       bidx_q, bidx_d;
  logic             last_q, last_d;
  logic             free;
  logic             load;
  logic             at_end;

  assign free   = !valid_q || out_o.ready;
  assign load   = burst_q && free;
  assign at_end = (idx_q == IDX_W'(PAYLOAD_BYTES - 1));

  // output register; a burst walks the store, read data lands in the following cycle
  always_comb begin
    valid_d  = valid_q && !out_o.ready;
    status_d = status_q;
    data_d   = data_q;
    bidx_d   = bidx_q;
    last_d   = last_q;
    burst_d  = burst_q;
    idx_d    = idx_q;
    if (res_i.err) begin
      valid_d  = 1'b1;
      status_d = res_i.status;
      data_d   = '0;
      bidx_d   = '0;
      last_d   = 1'b1;
    end else if (res_i.start) begin
      burst_d  = 1'b1;
      idx_d    = '0;
    end else if (load) begin
      valid_d  = 1'b1;
      status_d = ST_OK;
      data_d   = rdata_i;
      bidx_d   = 5'(idx_q);
      last_d   = at_end;
      if (at_end) begin
        burst_d = 1'b0;
        idx_d   = '0;
      end else begin
        idx_d   = idx_q + IDX_W'(1);
      end
    end
  end

  // the store is read at the entry the next output load needs
  assign raddr_o = idx_d;
  assign busy_o  = burst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      burst_q <= burst_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    bidx_q   <= bidx_d;
    last_q   <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.status     = status_q;
  assign out_o.data_byte  = data_q;
  assign out_o.byte_index = bidx_q;
  assign out_o.last       = last_q;

endmodule

`default_nettype wire

/* src/sensor_frame_receiver_unit.sv */
// an error result is registered and valid in the cycle after its request
// good frame: the checksum request sets the burst flag, then byte 0 is loaded
// into the output register, then one byte per cycle if out_o is ready; input waits
// out the burst, else one request per cycle if out_o is free (parser state loop)
// reset: async active low clears control state and sets hunt_limit 200,
// timeout_ticks 1000; the payload store needs no clearing, no sweep after reset
`default_nettype none
`include "sensor_frame_receiver_unit_defines.svh"

module sensor_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sfr_in_if.sink                     in_i,
  sfr_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  cfg_t             cfg;
  res_t             res;
  logic             acc;
  logic             busy;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rdata;
  logic             err_out;
  logic             err_clean;
  logic             ok_last;
  logic             last_at_end;

  // interlock: no new request while a burst reads the store
  assign in_i.ready = !busy && (!out_o.valid || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;

  sfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfr_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .acc_i     (acc),
    .cmd_i     (in_i.cmd),
    .rx_byte_i (in_i.rx_byte),
    .res_o     (res),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata)
  );

  sfr_store #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sfr_emit #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .busy_o  (busy),
    .out_o   (out_o)
  );

  // terms for the checks
  assign err_out     = out_o.valid && (out_o.status != ST_OK);
  assign err_clean   = (out_o.data_byte == 8'd0) && (out_o.byte_index == 5'd0) && out_o.last;
  assign ok_last     = out_o.valid && (out_o.status == ST_OK) && out_o.last;
  assign last_at_end = (out_o.byte_index == 5'(PAYLOAD_BYTES - 1));

  // checks
  `SFR_ASSERT_NOW(a_no_write_in_burst, busy, !we)
  `SFR_ASSERT_NEXT(a_start_opens_burst, res.start, busy)
  `SFR_ASSERT_NOW(a_error_fields, err_out, err_clean)
  `SFR_ASSERT_NOW(a_last_index, ok_last, last_at_end)

endmodule

`default_nettype wire
